FILE: hdl/ppu_pkg.sv
// Shared widths, register codes and depth codes of the palette pixel unpacker.
package ppu_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_ROW_WIDTH_DEF = 256;

    localparam int BYTE_W   = 8;
    localparam int RGB_W    = 24;
    localparam int BPP_W    = 6;
    localparam int ROW_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH      = 2'd1;

    // supported pixel depths
    localparam logic [BPP_W-1:0] BPP_1  = 6'd1;
    localparam logic [BPP_W-1:0] BPP_4  = 6'd4;
    localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
    localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
    localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

    localparam logic [BPP_W-1:0] BPP_RESET       = BPP_8;
    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 9'd16;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'd255;

    // request kinds on the input channel
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

endpackage

FILE: hdl/ppu_if.sv
// Channel interfaces of the palette pixel unpacker: config, input and pixel output.
interface ppu_cfg_if;
    import ppu_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface ppu_in_if;
    import ppu_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] pal_index;
    logic [BYTE_W-1:0] pal_red;
    logic [BYTE_W-1:0] pal_green;
    logic [BYTE_W-1:0] pal_blue;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, req_type, pal_index, pal_red, pal_green, pal_blue,
                    data_byte, input ready);
    modport sink   (input valid, req_type, pal_index, pal_red, pal_green, pal_blue,
                    data_byte, output ready);
endinterface

interface ppu_out_if;
    import ppu_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              row_end;
    logic              last;
    modport source (output valid, red, green, blue, alpha, row_end, last, input ready);
    modport sink   (input valid, red, green, blue, alpha, row_end, last, output ready);
endinterface

FILE: hdl/palette_pixel_unpacker.sv
// Top level of the palette pixel unpacker: palette memory, byte expander and pixel pipeline.
//
// Usage:
//   i_cfg  - register writes (index 0: bits per pixel, index 1: row width); always ready.
//            Write only while the block is idle. A depth write restarts 24/32-bit gathering.
//   i_in   - one word per file byte. req_type 0 writes palette entry pal_index at once;
//            req_type 1 carries a data byte, unpacked at the current depth.
//   o_out  - one RGBA pixel per word, with row_end on the last pixel of a row and last
//            on the final pixel a data byte causes.
// Throughput: one palette word or gathering byte per cycle while the expander is idle; a
//   data byte yields one pixel per cycle while the pipeline is not stalled: up to 8 at 1
//   bit, 2 at 4 bits, 1 otherwise. The single palette read port and the one pixel output
//   register set these rates. An accepted data byte is held in the expander; each pixel
//   then passes the palette read stage and the output register.
// Reset: depth 8, row width 16, row position and gathering cleared, pipeline empty.
//   Palette contents are undefined until written; no clearing pass is run.
// Stall: when o_out.ready is low the output register holds, the read stage holds its
//   registered palette data, and the expander and then i_in.ready back up in turn.
module palette_pixel_unpacker #(
    parameter int PALETTE_DEPTH = ppu_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_ROW_WIDTH = ppu_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ppu_cfg_if.sink       i_cfg,
    ppu_in_if.sink        i_in,
    ppu_out_if.source     o_out
);
    import ppu_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int PW = $clog2(MAX_ROW_WIDTH);
    localparam int EW = $clog2(MAX_ROW_WIDTH + 1);
    localparam int CW = ((EW > ROW_W) ? EW : ROW_W) + 1;
    localparam logic [BYTE_W:0] DEPTH_LIM = (BYTE_W + 1)'(PALETTE_DEPTH);
    localparam logic [CW-1:0]   MAX_W     = CW'(MAX_ROW_WIDTH);

    // configuration registers
    logic [BPP_W-1:0] r_bpp;
    logic [ROW_W-1:0] r_row_width;

    // gathering state for 24/32-bit pixels
    logic [1:0]       r_phase,    n_phase;
    logic [RGB_W-1:0] r_gathered, n_gathered;

    // expander: holds one data byte and hands out its pixels
    logic              r_busy;
    logic [BYTE_W-1:0] r_byte;
    logic [2:0]        r_k;
    logic [RGB_W-1:0]  r_rgb;
    logic [BYTE_W-1:0] r_alpha;
    logic [PW-1:0]     r_pos;

    // read stage
    logic              r_b_valid;
    logic [RGB_W-1:0]  r_pal_q;
    logic [RGB_W-1:0]  r_b_rgb;
    logic [BYTE_W-1:0] r_b_alpha;
    logic              r_b_use_pal;
    logic              r_b_black;
    logic              r_b_row_end;
    logic              r_b_last;

    // output register
    logic              r_c_valid;
    logic [RGB_W-1:0]  r_c_rgb;
    logic [BYTE_W-1:0] r_c_alpha;
    logic              r_c_row_end;
    logic              r_c_last;

    logic [RGB_W-1:0] mem [PALETTE_DEPTH];

    logic is_1, is_4, is_8, is_24, is_32, is_direct;
    assign is_1      = (r_bpp == BPP_1);
    assign is_4      = (r_bpp == BPP_4);
    assign is_8      = (r_bpp == BPP_8);
    assign is_24     = (r_bpp == BPP_24);
    assign is_32     = (r_bpp == BPP_32);
    assign is_direct = is_24 || is_32;

    // handshake chain from the output back to the input
    logic c_can_load, b_adv, b_can_load, issue, in_acc, cfg_acc;
    logic pix_end, pix_last, final_k;
    assign c_can_load = !r_c_valid || o_out.ready;
    assign b_adv      = r_b_valid && c_can_load;
    assign b_can_load = !r_b_valid || b_adv;
    assign issue      = r_busy && b_can_load;

    assign i_in.ready  = !r_busy || (issue && pix_last);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;

    // effective row width: zero reads as one, large values saturate
    logic [CW-1:0] eff_w, rw_ext;
    assign rw_ext = CW'(r_row_width);
    always_comb begin
        if (r_row_width == '0) begin
            eff_w = CW'(1);
        end else if (rw_ext > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = rw_ext;
        end
    end
    assign pix_end = (CW'(r_pos) + CW'(1)) >= eff_w;

    // pick the palette index of the current pixel, most significant bits first
    logic [BYTE_W-1:0] pix_idx;
    always_comb begin
        pix_idx = r_byte;
        final_k = 1'b1;
        if (is_1) begin
            pix_idx = {7'd0, r_byte[3'd7 - r_k]};
            final_k = (r_k == 3'd7);
        end else if (is_4) begin
            pix_idx = r_k[0] ? {4'd0, r_byte[3:0]} : {4'd0, r_byte[7:4]};
            final_k = r_k[0];
        end
    end
    assign pix_last = pix_end || final_k;

    // gathering of direct-colour bytes at acceptance
    logic load_exp;
    always_comb begin
        n_phase    = r_phase;
        n_gathered = r_gathered;
        load_exp   = 1'b0;
        if (in_acc && (i_in.req_type == REQ_PIXEL)) begin
            if (is_1 || is_4 || is_8) begin
                load_exp = 1'b1;
            end else if ((is_24 && (r_phase >= 2'd2)) || (is_32 && (r_phase == 2'd3))) begin
                load_exp   = 1'b1;
                n_phase    = 2'd0;
                n_gathered = '0;
            end else if (is_direct) begin
                n_phase = r_phase + 2'd1;
                case (r_phase)
                    2'd0:    n_gathered = r_gathered | {16'd0, i_in.data_byte};
                    2'd1:    n_gathered = r_gathered | {8'd0, i_in.data_byte, 8'd0};
                    2'd2:    n_gathered = r_gathered | {i_in.data_byte, 16'd0};
                    default: n_gathered = r_gathered;
                endcase
            end
        end
    end

    // configuration and gathering registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= BPP_RESET;
            r_row_width <= ROW_WIDTH_RESET;
            r_phase     <= '0;
            r_gathered  <= '0;
        end else if (cfg_acc && (i_cfg.index == CFG_BITS_PER_PIXEL)) begin
            r_bpp      <= i_cfg.data[BPP_W-1:0];
            r_phase    <= '0;
            r_gathered <= '0;
        end else begin
            if (cfg_acc && (i_cfg.index == CFG_ROW_WIDTH)) begin
                r_row_width <= i_cfg.data[ROW_W-1:0];
            end
            r_phase    <= n_phase;
            r_gathered <= n_gathered;
        end
    end

    // expander control and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_pos  <= '0;
        end else begin
            if (issue) begin
                r_pos <= pix_end ? '0 : r_pos + PW'(1);
                r_k   <= r_k + 3'd1;
                if (pix_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (load_exp) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end
        end
    end

    // expander payload; a completed direct pixel takes the gathered bytes
    always_ff @(posedge i_clk) begin
        if (load_exp) begin
            r_byte <= i_in.data_byte;
            if (is_24) begin
                r_rgb   <= {i_in.data_byte, r_gathered[15:0]};
                r_alpha <= ALPHA_OPAQUE;
            end else if (is_32) begin
                r_rgb   <= r_gathered;
                r_alpha <= i_in.data_byte;
            end else begin
                r_rgb   <= '0;
                r_alpha <= ALPHA_OPAQUE;
            end
        end
    end

    // palette memory: write on a palette word with an index in range, read on each issued pixel
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.req_type == REQ_PALETTE) && ({1'b0, i_in.pal_index} < DEPTH_LIM)) begin
            mem[i_in.pal_index[AW-1:0]] <= {i_in.pal_red, i_in.pal_green, i_in.pal_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pal_q <= mem[pix_idx[AW-1:0]];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_can_load) begin
            r_b_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_rgb     <= r_rgb;
            r_b_alpha   <= r_alpha;
            r_b_use_pal <= !is_direct;
            r_b_black   <= !is_direct && ({1'b0, pix_idx} >= DEPTH_LIM);
            r_b_row_end <= pix_end;
            r_b_last    <= pix_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_can_load) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            if (r_b_black) begin
                r_c_rgb <= '0;
            end else if (r_b_use_pal) begin
                r_c_rgb <= r_pal_q;
            end else begin
                r_c_rgb <= r_b_rgb;
            end
            r_c_alpha   <= r_b_alpha;
            r_c_row_end <= r_b_row_end;
            r_c_last    <= r_b_last;
        end
    end

    assign o_out.valid   = r_c_valid;
    assign o_out.red     = r_c_rgb[23:16];
    assign o_out.green   = r_c_rgb[15:8];
    assign o_out.blue    = r_c_rgb[7:0];
    assign o_out.alpha   = r_c_alpha;
    assign o_out.row_end = r_c_row_end;
    assign o_out.last    = r_c_last;

    // a palette word never overtakes pixel reads of an earlier byte
    a_pal_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.req_type == REQ_PALETTE)) |-> (!r_busy || (issue && pix_last)))
        else $error("palette write accepted while expander holds pending reads");

    // the row counter stays inside the widest row
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_pos) < MAX_W)
        else $error("row position beyond maximum row width");

    // at 4 bits a byte never yields more than two pixels
    a_nibble_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && is_4) |-> (r_k <= 3'd1))
        else $error("4-bit expander ran past its second pixel");

    // a stalled read stage keeps its palette data
    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_adv) |=> (r_b_valid && $stable(r_pal_q)))
        else $error("read stage lost data while stalled");

    // reset leaves the pipeline empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!r_busy && !r_b_valid && !r_c_valid))
        else $error("pipeline not empty after reset");

endmodule
